// ===== hdl/ate_pkg.sv =====
// Package for the alarm trigger evaluator: payload structs, mode, class,
// register and event codes, and configuration reset values.
// No dependencies; the interface and evaluator files refer to it by scoped names.
`default_nettype none

package ate_pkg;

  // Compare modes.
  localparam logic [2:0] MODE_GT     = 3'd0;
  localparam logic [2:0] MODE_LT     = 3'd1;
  localparam logic [2:0] MODE_EQ     = 3'd2;
  localparam logic [2:0] MODE_NE     = 3'd3;
  localparam logic [2:0] MODE_CHANGE = 3'd4;

  // Value classes that select a hysteresis.
  localparam logic [2:0] CLASS_TEMPERATURE = 3'd0;
  localparam logic [2:0] CLASS_CURRENT     = 3'd1;
  localparam logic [2:0] CLASS_VOLTAGE     = 3'd2;
  localparam logic [2:0] CLASS_PERCENT     = 3'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_GLOBAL_ENABLE    = 3'd0;
  localparam logic [2:0] REG_HYST_TEMPERATURE = 3'd1;
  localparam logic [2:0] REG_HYST_CURRENT     = 3'd2;
  localparam logic [2:0] REG_HYST_VOLTAGE     = 3'd3;
  localparam logic [2:0] REG_HYST_PERCENT     = 3'd4;

  // Configuration port widths and reset values.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam logic [15:0] HYST_TEMPERATURE_RST = 16'd20;
  localparam logic [15:0] HYST_CURRENT_RST     = 16'd100;
  localparam logic [15:0] HYST_VOLTAGE_RST     = 16'd100;
  localparam logic [15:0] HYST_PERCENT_RST     = 16'd20;

  // Event kinds.
  localparam logic EVENT_FIRE    = 1'b0;
  localparam logic EVENT_RESOLVE = 1'b1;

  // Width of the shared adder: 32-bit operands plus guard bits.
  localparam int ALU_W = 34;

  // One evaluation request.
  typedef struct packed {
    logic [2:0]         endpoint_id;
    logic [2:0]         trigger_id;
    logic [2:0]         compare_mode;
    logic [2:0]         value_class;
    logic signed [31:0] threshold;
    logic signed [31:0] sample;
    logic [31:0]        holdoff_ms;
    logic [31:0]        now_ms;
    logic [1:0]         severity;
  } in_item_t;

  // One emitted event.
  typedef struct packed {
    logic [2:0]  event_endpoint;
    logic [2:0]  event_trigger;
    logic        event_kind;
    logic [1:0]  event_level;
    logic [31:0] event_time;
  } out_item_t;

  // Per-trigger state word kept in the slot memory.
  typedef struct packed {
    logic       fired;
    logic       state_valid;
    logic [7:0] last_state;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== hdl/ate_if.sv =====
// Valid/ready channel interfaces for requests and events of the alarm
// trigger evaluator. Depends on ate_pkg for the payload types.
`default_nettype none

interface ate_in_if;
  logic              valid;
  logic              ready;
  ate_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ate_out_if;
  logic               valid;
  logic               ready;
  ate_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/ate_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module ate_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/alarm_trigger_evaluator.sv =====
// Alarm trigger evaluator: an accepted request steps through ADJ, CMP and DONE, with
// TIME and COOL after CMP when a fire runs the cooldown check; the next request is
// accepted back in IDLE. DONE waits while an unread event holds the output register,
// and the event is registered from DONE. One shared 34-bit adder does the arithmetic
// step by step; an ignored request is dropped in IDLE. After reset a clearing pass
// zeroes all slot entries, one per cycle, accepting no request. Uses ate_pkg/if/ram.
`default_nettype none

module alarm_trigger_evaluator #(
  parameter int ENDPOINTS             = 8,
  parameter int TRIGGERS_PER_ENDPOINT = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  ate_in_if.sink                                 in_if,
  ate_out_if.source                              out_if,
  input  wire logic                              cfg_we,
  input  wire logic [ate_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [ate_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int SLOTS  = ENDPOINTS * TRIGGERS_PER_ENDPOINT;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EP_W   = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;
  localparam int AW     = ate_pkg::ALU_W;

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ADJ   = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_TIME  = 3'd4;
  localparam logic [2:0] S_COOL  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [SLOT_W-1:0]  clr_cnt_r;
  ate_pkg::in_item_t  item_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [EP_W-1:0]    ep_idx_r;
  ate_pkg::entry_t    ent_r;
  logic [AW-1:0]      acc_r;
  logic               kind_r;
  logic               emit_r;

  logic               global_enable_r;
  logic [15:0]        hyst_temperature_r;
  logic [15:0]        hyst_current_r;
  logic [15:0]        hyst_voltage_r;
  logic [15:0]        hyst_percent_r;
  logic [31:0]        last_time_r [ENDPOINTS];

  logic               out_valid_r;
  ate_pkg::out_item_t out_data_r;

  logic               accept;
  logic               in_range;
  logic               mode_ok;
  logic [SLOT_W-1:0]  in_slot;
  logic [15:0]        hyst_sel;
  logic [AW-1:0]      alu_a, alu_b, alu_res;
  logic               alu_sub;
  logic               alu_neg;
  logic               hit;
  logic               hit_kind;
  ate_pkg::entry_t    ent_upd;
  logic               out_free;
  logic               load;

  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  ate_pkg::entry_t    ram_wdata;
  ate_pkg::entry_t    ram_rdata;

  // Request handshake and admission checks.
  assign accept   = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == S_IDLE);
  assign in_range = ({3'b000, in_if.data.endpoint_id} < 6'(ENDPOINTS)) &&
                    ({3'b000, in_if.data.trigger_id} < 6'(TRIGGERS_PER_ENDPOINT));
  assign mode_ok  = (in_if.data.compare_mode <= ate_pkg::MODE_CHANGE);
  assign in_slot  = SLOT_W'(32'(in_if.data.endpoint_id) * 32'(TRIGGERS_PER_ENDPOINT) +
                            32'(in_if.data.trigger_id));

  // Hysteresis selected by value class; unknown classes use zero.
  always_comb begin
    case (item_r.value_class)
      ate_pkg::CLASS_TEMPERATURE: hyst_sel = hyst_temperature_r;
      ate_pkg::CLASS_CURRENT:     hyst_sel = hyst_current_r;
      ate_pkg::CLASS_VOLTAGE:     hyst_sel = hyst_voltage_r;
      ate_pkg::CLASS_PERCENT:     hyst_sel = hyst_percent_r;
      default:                    hyst_sel = 16'd0;
    endcase
  end

  // Operand selection for the shared adder in each step.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    unique case (state_r)
      S_ADJ: begin
        // Resolve level: threshold minus hysteresis for GT, plus for LT.
        alu_a   = {{2{item_r.threshold[31]}}, item_r.threshold};
        alu_b   = {18'd0, hyst_sel};
        alu_sub = (item_r.compare_mode == ate_pkg::MODE_GT);
      end
      S_CMP: begin
        // The difference is negative exactly when the crossing condition holds.
        if (item_r.compare_mode == ate_pkg::MODE_GT) begin
          if (ent_r.fired) begin
            alu_a = {{2{item_r.sample[31]}}, item_r.sample};
            alu_b = acc_r;
          end else begin
            alu_a = {{2{item_r.threshold[31]}}, item_r.threshold};
            alu_b = {{2{item_r.sample[31]}}, item_r.sample};
          end
        end else begin
          if (ent_r.fired) begin
            alu_a = acc_r;
            alu_b = {{2{item_r.sample[31]}}, item_r.sample};
          end else begin
            alu_a = {{2{item_r.sample[31]}}, item_r.sample};
            alu_b = {{2{item_r.threshold[31]}}, item_r.threshold};
          end
        end
      end
      S_TIME: begin
        alu_a = {2'b00, item_r.now_ms};
        alu_b = {2'b00, last_time_r[ep_idx_r]};
      end
      S_COOL: begin
        alu_a = {2'b00, acc_r[31:0]};
        alu_b = {2'b00, item_r.holdoff_ms};
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
      end
    endcase
  end

  assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);
  assign alu_neg = alu_res[AW-1];

  // Trigger decision and the updated slot entry.
  always_comb begin
    hit      = 1'b0;
    hit_kind = ate_pkg::EVENT_FIRE;
    ent_upd  = ent_r;
    case (item_r.compare_mode)
      ate_pkg::MODE_GT, ate_pkg::MODE_LT: begin
        hit = alu_neg;
      end
      ate_pkg::MODE_EQ: begin
        hit = ent_r.fired ^ (item_r.sample[7:0] == item_r.threshold[7:0]);
      end
      ate_pkg::MODE_NE: begin
        hit = ent_r.fired ^ (item_r.sample[7:0] != item_r.threshold[7:0]);
      end
      default: begin
        hit = ent_r.state_valid && (item_r.sample[7:0] != ent_r.last_state);
        ent_upd.last_state  = item_r.sample[7:0];
        ent_upd.state_valid = 1'b1;
      end
    endcase
    if (item_r.compare_mode != ate_pkg::MODE_CHANGE) begin
      hit_kind = ent_r.fired ? ate_pkg::EVENT_RESOLVE : ate_pkg::EVENT_FIRE;
      if (hit) begin
        ent_upd.fired = !ent_r.fired;
      end
    end
  end

  // Final step waits for a free output register.
  assign out_free = !out_valid_r || out_if.ready;
  assign load     = (state_r == S_DONE) && out_free && emit_r;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == SLOT_W'(SLOTS - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept && global_enable_r && in_range && mode_ok) state_nxt = S_ADJ;
      end
      S_ADJ: state_nxt = S_CMP;
      S_CMP: begin
        if (hit && hit_kind == ate_pkg::EVENT_FIRE) state_nxt = S_TIME;
        else state_nxt = S_DONE;
      end
      S_TIME: state_nxt = S_COOL;
      S_COOL: state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // Request capture and per-step working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r   <= in_if.data;
      slot_r   <= in_slot;
      ep_idx_r <= EP_W'(in_if.data.endpoint_id);
    end
    unique case (state_r)
      S_ADJ: begin
        ent_r <= ram_rdata;
        acc_r <= alu_res;
      end
      S_CMP: begin
        ent_r  <= ent_upd;
        kind_r <= hit_kind;
        emit_r <= hit;
      end
      S_TIME: acc_r <= alu_res;
      S_COOL: begin
        // A fire inside the cooldown is dropped, but the flag update stands.
        if (alu_neg) emit_r <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Configuration registers and per-endpoint alert times.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      global_enable_r    <= 1'b0;
      hyst_temperature_r <= ate_pkg::HYST_TEMPERATURE_RST;
      hyst_current_r     <= ate_pkg::HYST_CURRENT_RST;
      hyst_voltage_r     <= ate_pkg::HYST_VOLTAGE_RST;
      hyst_percent_r     <= ate_pkg::HYST_PERCENT_RST;
      for (int i = 0; i < ENDPOINTS; i++) begin
        last_time_r[i] <= 32'd0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ate_pkg::REG_GLOBAL_ENABLE:    global_enable_r    <= cfg_wdata[0];
          ate_pkg::REG_HYST_TEMPERATURE: hyst_temperature_r <= cfg_wdata;
          ate_pkg::REG_HYST_CURRENT:     hyst_current_r     <= cfg_wdata;
          ate_pkg::REG_HYST_VOLTAGE:     hyst_voltage_r     <= cfg_wdata;
          ate_pkg::REG_HYST_PERCENT:     hyst_percent_r     <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (load && kind_r == ate_pkg::EVENT_FIRE) begin
        last_time_r[ep_idx_r] <= item_r.now_ms;
      end
    end
  end

  // Output register for the event channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.event_endpoint <= item_r.endpoint_id;
      out_data_r.event_trigger  <= item_r.trigger_id;
      out_data_r.event_kind     <= kind_r;
      out_data_r.event_level    <= item_r.severity;
      out_data_r.event_time     <= item_r.now_ms;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  // Slot memory: cleared after reset, written back at the end of a request.
  assign ram_we    = (state_r == S_CLEAR) || ((state_r == S_DONE) && out_free);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_cnt_r : slot_r;
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : ent_r;

  ate_ram #(
    .WIDTH (ate_pkg::ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_slot),
    .rdata (ram_rdata)
  );

  // A request refused by the enable never starts the sequencer.
  a_disabled_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !global_enable_r) |=> (state_r == S_IDLE))
    else $error("disabled request started the sequencer");

  // A resolve is only emitted for a trigger that was fired.
  a_resolve_fired: assert property (@(posedge clk) disable iff (!rst_n)
    (load && kind_r == ate_pkg::EVENT_RESOLVE) |-> !ent_r.fired)
    else $error("resolve emitted for a trigger that was not fired");

  // The cooldown steps are only taken for fire events.
  a_cool_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TIME || state_r == S_COOL) |-> (kind_r == ate_pkg::EVENT_FIRE))
    else $error("cooldown check on a resolve");

  // An emitted fire stamps the endpoint alert time.
  a_fire_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    (load && kind_r == ate_pkg::EVENT_FIRE) |=> (last_time_r[ep_idx_r] == item_r.now_ms))
    else $error("fire did not update the alert time");

  // No event leaves during the clearing pass.
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("event valid during clearing pass");

endmodule

`default_nettype wire
